[hw/rtl/pointwise_conv_int8_bias_requant_assert.svh]
// Assertion macros used by the RTL of the pointwise convolution block.
`ifndef POINTWISE_CONV_INT8_BIAS_REQUANT_ASSERT_SVH
`define POINTWISE_CONV_INT8_BIAS_REQUANT_ASSERT_SVH
// Assert that an antecedent implies a consequent on the same edge.
`define PCQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent on the next edge.
`define PCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hw/rtl/pcq_pkg.sv]
`timescale 1ns / 1ps
package pcq_pkg;
    // Request types of the input channel.
    localparam logic [1:0] REQ_WEIGHT = 2'd0;
    localparam logic [1:0] REQ_BIAS   = 2'd1;
    localparam logic [1:0] REQ_ACT    = 2'd2;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_IN_GROUPS  = 2'd0;
    localparam logic [1:0] REG_OUT_GROUPS = 2'd1;
    localparam logic [1:0] REG_SHIFT      = 2'd2;

    // Saturation limits of the int8 results.
    localparam logic signed [47:0] SAT_MAX = 48'sd127;
    localparam logic signed [47:0] SAT_MIN = -48'sd128;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [12:0]       addr;
        logic signed [7:0] lane7;
        logic signed [7:0] lane6;
        logic signed [7:0] lane5;
        logic signed [7:0] lane4;
        logic signed [7:0] lane3;
        logic signed [7:0] lane2;
        logic signed [7:0] lane1;
        logic signed [7:0] lane0;
        logic signed [31:0] bias_value;
    } t_in_item;

    typedef struct packed {
        logic [4:0]        out_group;
        logic signed [7:0] ch7;
        logic signed [7:0] ch6;
        logic signed [7:0] ch5;
        logic signed [7:0] ch4;
        logic signed [7:0] ch3;
        logic signed [7:0] ch2;
        logic signed [7:0] ch1;
        logic signed [7:0] ch0;
        logic              last;
    } t_out_item;
endpackage

[hw/rtl/pcq_ram.sv]
`timescale 1ns / 1ps
module pcq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/pcq_mac.sv]
`timescale 1ns / 1ps
module pcq_mac (
    input  logic        i_clk,
    input  logic        i_clr,
    input  logic        i_acc,
    input  logic [31:0] i_bias,
    input  logic [7:0]  i_act,
    input  logic [63:0] i_wrow,
    output logic [8*48-1:0] o_acc
);
    // Eight lanes, one per output channel; each multiplies the same activation.
    logic signed [47:0] r_acc [8];
    logic signed [47:0] n_acc [8];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            n_acc[k] = r_acc[k];
            if (i_clr) begin
                n_acc[k] = 48'(signed'(i_bias));
            end else if (i_acc) begin
                n_acc[k] = r_acc[k] + 48'(signed'(i_act) * signed'(i_wrow[8*k +: 8]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) begin
            r_acc[k] <= n_acc[k];
        end
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            o_acc[48*k +: 48] = r_acc[k];
        end
    end
endmodule

[hw/rtl/pointwise_conv_int8_bias_requant.sv]
`timescale 1ns / 1ps
// Pointwise int8 convolution with int32 bias and rounding requantization.
// Loads (weight rows, biases) and activation groups that do not complete a
// pixel pass through a wait state before the next item is accepted. The
// completing group runs a sequencer over each output group: the bias of each
// of its eight channels is loaded one per cycle, then one shared row of eight
// multiply-accumulate lanes consumes one weight row per cycle, then a
// requantize step and the result transaction.
module pointwise_conv_int8_bias_requant #(
    parameter int MAX_IN_GROUPS  = 32,
    parameter int MAX_OUT_GROUPS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  pcq_pkg::t_in_item    i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pcq_pkg::t_out_item   o_data
);
    import pcq_pkg::*;
    `include "pointwise_conv_int8_bias_requant_assert.svh"

    localparam int WDEPTH = MAX_IN_GROUPS * MAX_OUT_GROUPS * 8;
    localparam int BDEPTH = MAX_OUT_GROUPS * 8;
    localparam int WAW = $clog2(WDEPTH);
    localparam int BAW = $clog2(BDEPTH);
    localparam int PAW = (MAX_IN_GROUPS > 1) ? $clog2(MAX_IN_GROUPS) : 1;
    localparam int PD  = (MAX_IN_GROUPS > 1) ? MAX_IN_GROUPS : 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BIAS = 3'd1;
    localparam logic [2:0] S_MAC  = 3'd2;
    localparam logic [2:0] S_DRN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    // Configuration registers.
    logic [5:0] r_in_groups, r_out_groups;
    logic [4:0] r_shift;
    logic       cfg_we;
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_groups  <= 6'd1;
            r_out_groups <= 6'd1;
            r_shift      <= 5'd0;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_IN_GROUPS:  r_in_groups  <= pwdata[5:0];
                REG_OUT_GROUPS: r_out_groups <= pwdata[5:0];
                REG_SHIFT:      r_shift      <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_IN_GROUPS:  prdata = {26'd0, r_in_groups};
            REG_OUT_GROUPS: prdata = {26'd0, r_out_groups};
            REG_SHIFT:      prdata = {27'd0, r_shift};
            default:        prdata = 32'd0;
        endcase
    end

    // Effective group counts.
    logic [6:0] ig_eff, og_eff;
    always_comb begin
        ig_eff = (r_in_groups == 6'd0) ? 7'd1 :
                 ({1'b0, r_in_groups} > 7'(MAX_IN_GROUPS)) ? 7'(MAX_IN_GROUPS)
                 : {1'b0, r_in_groups};
        og_eff = (r_out_groups == 6'd0) ? 7'd1 :
                 ({1'b0, r_out_groups} > 7'(MAX_OUT_GROUPS)) ? 7'(MAX_OUT_GROUPS)
                 : {1'b0, r_out_groups};
    end

    logic [2:0]  r_state;
    logic [5:0]  r_gcnt;
    logic [6:0]  r_og;
    logic [6:0]  r_g;
    logic [2:0]  r_c;
    logic [3:0]  r_k;
    logic        r_mac_en;
    logic [2:0]  r_mac_c;
    logic        r_bias_en;
    logic        r_bias_first;
    logic [2:0]  r_bias_k;
    logic [31:0] r_bias [8];
    t_out_item   r_out;
    logic        r_ovalid;

    logic [63:0] packed_lanes;
    assign packed_lanes = {i_data.lane7, i_data.lane6, i_data.lane5, i_data.lane4,
                           i_data.lane3, i_data.lane2, i_data.lane1, i_data.lane0};

    logic acc_in;
    assign o_ready = (r_state == S_IDLE);
    assign acc_in  = i_valid && o_ready;

    // Weight store.
    logic         w_we;
    logic [WAW-1:0] w_raddr;
    logic [63:0]  w_rdata;
    logic [17:0]  row_full;
    assign w_we = acc_in && (i_data.req_type == REQ_WEIGHT) && (32'(i_data.addr) < WDEPTH);
    assign row_full = ((18'(r_og) * 18'(ig_eff)) + 18'(r_g)) * 18'd8 + 18'(r_c);
    assign w_raddr = row_full[WAW-1:0];
    pcq_ram #(.WIDTH(64), .DEPTH(WDEPTH)) u_wram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(WAW'(i_data.addr)),
        .i_wdata(packed_lanes), .i_raddr(w_raddr), .o_rdata(w_rdata));

    // Bias store.
    logic           b_we;
    logic [BAW-1:0] b_raddr;
    logic [31:0]    b_rdata;
    logic [9:0]     bidx;
    assign b_we = acc_in && (i_data.req_type == REQ_BIAS) && (32'(i_data.addr) < BDEPTH);
    assign bidx = 10'(r_og) * 10'd8 + 10'(r_k[2:0]);
    assign b_raddr = bidx[BAW-1:0];
    pcq_ram #(.WIDTH(32), .DEPTH(BDEPTH)) u_bram (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(BAW'(i_data.addr)),
        .i_wdata(i_data.bias_value), .i_raddr(b_raddr), .o_rdata(b_rdata));

    // Pixel buffer.
    logic         p_we;
    logic [63:0]  p_rdata;
    assign p_we = acc_in && (i_data.req_type == REQ_ACT) && (32'(r_gcnt) < MAX_IN_GROUPS);
    pcq_ram #(.WIDTH(64), .DEPTH(PD)) u_pbuf (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(r_gcnt[PAW-1:0]),
        .i_wdata(packed_lanes), .i_raddr(r_g[PAW-1:0]), .o_rdata(p_rdata));

    // MAC lanes: activation byte chosen by the delayed channel index.
    logic [8*48-1:0] acc_all;
    logic [8*32-1:0] bias_flat;
    logic [7:0]      act_sel;
    assign act_sel = p_rdata[8*r_mac_c +: 8];
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            bias_flat[32*k +: 32] = r_bias[k];
        end
    end
    pcq_mac u_mac (
        .i_clk(i_clk), .i_clr(r_bias_first), .i_acc(r_mac_en),
        .i_bias(32'd0), .i_act(act_sel), .i_wrow(w_rdata), .o_acc(acc_all));

    // Requantize: bias added here, rounding half, shift and saturate.
    t_out_item n_out;
    always_comb begin
        logic signed [47:0] v [8];
        logic signed [47:0] rnd;
        rnd = (r_shift == 5'd0) ? 48'sd0 : (48'sd1 <<< (r_shift - 5'd1));
        for (int k = 0; k < 8; k++) begin
            v[k] = (signed'(acc_all[48*k +: 48]) + 48'(signed'(bias_flat[32*k +: 32]))
                    + rnd) >>> r_shift;
            if (v[k] > SAT_MAX) v[k] = SAT_MAX;
            if (v[k] < SAT_MIN) v[k] = SAT_MIN;
        end
        n_out.out_group = r_og[4:0];
        n_out.ch0 = v[0][7:0]; n_out.ch1 = v[1][7:0];
        n_out.ch2 = v[2][7:0]; n_out.ch3 = v[3][7:0];
        n_out.ch4 = v[4][7:0]; n_out.ch5 = v[5][7:0];
        n_out.ch6 = v[6][7:0]; n_out.ch7 = v[7][7:0];
        n_out.last = (r_og + 7'd1 == og_eff);
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        r_mac_c <= r_c;
        r_bias_k <= r_k[2:0];
        if (r_bias_en) begin
            r_bias[r_bias_k] <= b_rdata;
        end
        if (r_state == S_DRN) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gcnt <= 6'd0;
            r_og <= 7'd0; r_g <= 7'd0; r_c <= 3'd0; r_k <= 4'd0;
            r_mac_en <= 1'b0; r_bias_en <= 1'b0; r_bias_first <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_mac_en <= 1'b0;
            r_bias_en <= 1'b0;
            r_bias_first <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc_in && (i_data.req_type == REQ_ACT)) begin
                        if (7'(r_gcnt) + 7'd1 < ig_eff) begin
                            r_gcnt <= r_gcnt + 6'd1;
                            r_state <= S_WAIT;
                        end else begin
                            r_gcnt <= 6'd0;
                            r_og <= 7'd0; r_k <= 4'd0;
                            r_state <= S_BIAS;
                        end
                    end else if (acc_in) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: r_state <= S_IDLE;
                S_BIAS: begin
                    if (r_k == 4'd8) begin
                        r_bias_first <= 1'b1;
                        r_g <= 7'd0; r_c <= 3'd0;
                        r_state <= S_MAC;
                    end else begin
                        r_bias_en <= 1'b1;
                        r_k <= r_k + 4'd1;
                    end
                end
                S_MAC: begin
                    r_mac_en <= 1'b1;
                    if (r_c == 3'd7) begin
                        r_c <= 3'd0;
                        if (r_g + 7'd1 == ig_eff) begin
                            r_state <= S_DRN;
                        end else begin
                            r_g <= r_g + 7'd1;
                        end
                    end else begin
                        r_c <= r_c + 3'd1;
                    end
                end
                S_DRN: begin
                    if (!r_mac_en) begin
                        r_ovalid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_ovalid <= 1'b0;
                        if (r_og + 7'd1 == og_eff) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_og <= r_og + 7'd1;
                            r_k <= 4'd0;
                            r_state <= S_BIAS;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // Checks on the sequencer.
    `PCQ_ASSERT_IMP(a_valid_only_out, i_clk, i_rst_n, o_valid, r_state == S_OUT, "result valid outside output state")
    `PCQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data), "pending result changed")
    `PCQ_ASSERT_IMP(a_no_mac_idle, i_clk, i_rst_n, r_state == S_IDLE, !r_mac_en, "accumulate in idle")
endmodule
